[hdl/tlms_pkg.sv]
// tlms_pkg: shared constants and types of the two-list merge sorter
// no dependencies; compiled first

package tlms_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int VALUE_W    = 32;
  localparam int MODE_W     = 2;

  typedef logic [MODE_W-1:0]  mode_t;
  typedef logic [VALUE_W-1:0] value_t;

  localparam mode_t MODE_APPEND_FIRST  = 2'd0;
  localparam mode_t MODE_APPEND_SECOND = 2'd1;
  localparam mode_t MODE_MERGE         = 2'd2;

endpackage

[hdl/tlms_if.sv]
// tlms_if: command and result channel interfaces of the two-list merge sorter
// depends on tlms_pkg

interface tlms_cmd_if;
  logic                  valid;
  logic                  ready;
  tlms_pkg::mode_t       mode;
  logic signed [tlms_pkg::VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface tlms_res_if;
  logic                  valid;
  logic                  ready;
  logic signed [tlms_pkg::VALUE_W-1:0] sorted_value;
  logic                  last;
  logic                  empty_res;
  logic                  overflow;

  modport source (output valid, output sorted_value, output last, output empty_res,
                  output overflow, input ready);
  modport sink   (input valid, input sorted_value, input last, input empty_res,
                  input overflow, output ready);
endinterface

[hdl/tlms_mem.sv]
// tlms_mem: value memory holding both lists, one write and one registered read port
// depends on tlms_pkg

module tlms_mem #(
  parameter int DEPTH = 2 * tlms_pkg::LIST_DEPTH
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  tlms_pkg::value_t             wr_data,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr,
  output tlms_pkg::value_t             rd_data
);

  tlms_pkg::value_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hdl/two_list_merge_sorter.sv]
// Two-list merge sorter: appends signed values to two lists and, on a merge command,
// emits both lists joined and sorted ascending. A merge of n values sorts in place in
// one shared memory with a single read port and one signed comparator by exchange sort,
// then reads and emits the sorted beats in order; the command channel is not ready
// meanwhile. The final result beat waits in the output register while new commands are
// taken. No clearing pass after reset.
// depends on tlms_pkg, tlms_if, tlms_mem

module two_list_merge_sorter #(
  parameter int LIST_DEPTH = tlms_pkg::LIST_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  tlms_cmd_if.sink       cmd,
  tlms_res_if.source     res
);

  localparam int MEM_DEPTH = 2 * LIST_DEPTH;
  localparam int IDX_W     = $clog2(MEM_DEPTH);
  localparam int CNT_W     = $clog2(LIST_DEPTH + 1);
  localparam int TOT_W     = $clog2(MEM_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RD_I, S_LD_I, S_CMP, S_WR_I, S_EM_RD, S_EM_LD, S_EMPTY
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    first_count;
  logic [CNT_W-1:0]    second_count;
  logic                overflow_seen;
  logic [CNT_W-1:0]    sort_n1;
  logic [TOT_W-1:0]    n_total;
  logic                merge_ovf;
  logic [IDX_W-1:0]    i;
  logic [IDX_W-1:0]    j;
  logic [IDX_W-1:0]    k;
  tlms_pkg::value_t    cur;

  logic                out_valid;
  tlms_pkg::value_t    out_value;
  logic                out_last;
  logic                out_empty;
  logic                out_ovf;

  logic                mem_wr_en;
  logic [IDX_W-1:0]    mem_wr_addr;
  tlms_pkg::value_t    mem_wr_data;
  logic [IDX_W-1:0]    mem_rd_addr;
  tlms_pkg::value_t    mem_rd_data;

  logic                cmd_beat;
  logic                out_free;
  logic                out_load;
  logic                swap;
  logic                j_last;
  logic                k_last;
  logic                sort_more;
  logic [TOT_W-1:0]    merge_total;

  // logical position in the joined list to memory address
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] pos,
                                            input logic [CNT_W-1:0] n1);
    logic [IDX_W-1:0] n1x;
    n1x = IDX_W'(n1);
    if (pos < n1x) begin
      return pos;
    end
    return pos - n1x + IDX_W'(LIST_DEPTH);
  endfunction

  assign cmd_beat    = cmd.valid && cmd.ready;
  assign cmd.ready   = (state == S_IDLE);
  assign out_free    = !out_valid || res.ready;
  assign out_load    = (state == S_EM_LD || state == S_EMPTY) && out_free;
  assign swap        = $signed(cur) > $signed(mem_rd_data);
  assign j_last      = (TOT_W'(j) + TOT_W'(1)) == n_total;
  assign k_last      = (TOT_W'(k) + TOT_W'(1)) == n_total;
  assign sort_more   = (TOT_W'(i) + TOT_W'(2)) < n_total;
  assign merge_total = TOT_W'(first_count) + TOT_W'(second_count);

  assign res.valid        = out_valid;
  assign res.sorted_value = out_value;
  assign res.last         = out_last;
  assign res.empty_res    = out_empty;
  assign res.overflow     = out_ovf;

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = cmd.value;
    mem_rd_addr = '0;
    case (state)
      S_IDLE: begin
        if (cmd_beat && cmd.mode == tlms_pkg::MODE_APPEND_FIRST) begin
          mem_wr_en   = (first_count < CNT_W'(LIST_DEPTH));
          mem_wr_addr = IDX_W'(first_count);
        end else if (cmd_beat && cmd.mode == tlms_pkg::MODE_APPEND_SECOND) begin
          mem_wr_en   = (second_count < CNT_W'(LIST_DEPTH));
          mem_wr_addr = IDX_W'(LIST_DEPTH) + IDX_W'(second_count);
        end
      end
      S_RD_I: mem_rd_addr = phys(i, sort_n1);
      S_LD_I: mem_rd_addr = phys(j, sort_n1);
      S_CMP: begin
        mem_rd_addr = j_last ? phys(j, sort_n1) : phys(j + IDX_W'(1), sort_n1);
        mem_wr_en   = swap;
        mem_wr_addr = phys(j, sort_n1);
        mem_wr_data = cur;
      end
      S_WR_I: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = phys(i, sort_n1);
        mem_wr_data = cur;
      end
      S_EM_RD: mem_rd_addr = phys(k, sort_n1);
      S_EM_LD: mem_rd_addr = phys(k, sort_n1);
      default: mem_rd_addr = '0;
    endcase
  end

  tlms_mem #(
    .DEPTH (MEM_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      first_count   <= '0;
      second_count  <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && res.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_beat) begin
            case (cmd.mode)
              tlms_pkg::MODE_APPEND_FIRST: begin
                if (first_count < CNT_W'(LIST_DEPTH)) begin
                  first_count <= first_count + CNT_W'(1);
                end else begin
                  overflow_seen <= 1'b1;
                end
              end
              tlms_pkg::MODE_APPEND_SECOND: begin
                if (second_count < CNT_W'(LIST_DEPTH)) begin
                  second_count <= second_count + CNT_W'(1);
                end else begin
                  overflow_seen <= 1'b1;
                end
              end
              tlms_pkg::MODE_MERGE: begin
                sort_n1       <= first_count;
                n_total       <= merge_total;
                merge_ovf     <= overflow_seen;
                first_count   <= '0;
                second_count  <= '0;
                overflow_seen <= 1'b0;
                i             <= '0;
                k             <= '0;
                if (merge_total == '0) begin
                  state <= S_EMPTY;
                end else if (merge_total == TOT_W'(1)) begin
                  state <= S_EM_RD;
                end else begin
                  state <= S_RD_I;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_RD_I: begin
          j     <= i + IDX_W'(1);
          state <= S_LD_I;
        end
        S_LD_I: begin
          cur   <= mem_rd_data;
          state <= S_CMP;
        end
        S_CMP: begin
          if (swap) begin
            cur <= mem_rd_data;
          end
          if (j_last) begin
            state <= S_WR_I;
          end else begin
            j <= j + IDX_W'(1);
          end
        end
        S_WR_I: begin
          if (sort_more) begin
            i     <= i + IDX_W'(1);
            state <= S_RD_I;
          end else begin
            state <= S_EM_RD;
          end
        end
        S_EM_RD: begin
          state <= S_EM_LD;
        end
        S_EM_LD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_value <= mem_rd_data;
            out_last  <= k_last;
            out_empty <= 1'b0;
            out_ovf   <= merge_ovf;
            if (k_last) begin
              state <= S_IDLE;
            end else begin
              k     <= k + IDX_W'(1);
              state <= S_EM_RD;
            end
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_value <= '0;
            out_last  <= 1'b1;
            out_empty <= 1'b1;
            out_ovf   <= merge_ovf;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    first_count <= CNT_W'(LIST_DEPTH) && second_count <= CNT_W'(LIST_DEPTH))
    else $error("list count beyond depth");

  a_merge_clears: assert property (@(posedge clk) disable iff (rst)
    cmd_beat && cmd.mode == tlms_pkg::MODE_MERGE |=>
      first_count == '0 && second_count == '0 && !overflow_seen)
    else $error("merge did not clear the lists");

  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> j > i && TOT_W'(j) < n_total)
    else $error("compare index out of order");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_empty |-> out_last)
    else $error("empty result not marked last");
`endif

endmodule
